>>> rtl/mncp_pkg.sv
// ----------------------------------------------------------------------------
// mncp_pkg
// Shared types and constants of the mobile-number codepoint parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mncp_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned NUM_W   = 34;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned DIGIT_W = 4;

    // Codepoints of interest
    localparam logic [CP_W-1:0] CP_PLUS       = 21'h00002B;
    localparam logic [CP_W-1:0] CP_ASCII_0    = 21'h000030;
    localparam logic [CP_W-1:0] CP_ASCII_9    = 21'h000039;
    localparam logic [CP_W-1:0] CP_ARABIC_0   = 21'h000660;
    localparam logic [CP_W-1:0] CP_ARABIC_9   = 21'h000669;
    localparam logic [CP_W-1:0] CP_EXTARAB_0  = 21'h0006F0;
    localparam logic [CP_W-1:0] CP_EXTARAB_9  = 21'h0006F9;

    // Digit values the prefix expects
    localparam logic [DIGIT_W-1:0] DIGIT_ZERO  = 4'd0;
    localparam logic [DIGIT_W-1:0] DIGIT_EIGHT = 4'd8;
    localparam logic [DIGIT_W-1:0] DIGIT_NINE  = 4'd9;

    // Accumulator value at the start of a string
    localparam logic [NUM_W-1:0] ACC_START = 34'd9;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,  // nothing seen yet
        PH_PLUS   = 3'd1,  // after "+"
        PH_PLUS9  = 3'd2,  // after "+9"
        PH_MOBILE = 3'd3,  // waiting for the mobile "9"
        PH_TAIL   = 3'd4   // collecting tail digits
    } t_phase;

    // Classification of one codepoint
    typedef struct packed {
        logic               is_plus;
        logic               is_digit;
        logic [DIGIT_W-1:0] digit;
    } t_cp_class;

endpackage : mncp_pkg

`default_nettype wire

>>> rtl/mncp_digit_decode.sv
// ----------------------------------------------------------------------------
// mncp_digit_decode
// Classifies a codepoint as "+", a decimal digit in one of three scripts
// (ASCII, Arabic-Indic, Extended Arabic-Indic) with its value, or neither.
// ----------------------------------------------------------------------------
`default_nettype none

module mncp_digit_decode
    import mncp_pkg::*;
(
    input  wire logic [CP_W-1:0] i_code_point,
    output t_cp_class            o_class
);

    logic                 w_ascii;
    logic                 w_arabic;
    logic                 w_extarab;
    logic [DIGIT_W-1:0]   w_offset;

    assign w_ascii   = (i_code_point >= CP_ASCII_0)   && (i_code_point <= CP_ASCII_9);
    assign w_arabic  = (i_code_point >= CP_ARABIC_0)  && (i_code_point <= CP_ARABIC_9);
    assign w_extarab = (i_code_point >= CP_EXTARAB_0) && (i_code_point <= CP_EXTARAB_9);

    // Only the low bits of the offset matter: each range spans ten codepoints
    always_comb begin
        priority if (w_ascii) begin
            w_offset = DIGIT_W'(i_code_point - CP_ASCII_0);
        end else if (w_arabic) begin
            w_offset = DIGIT_W'(i_code_point - CP_ARABIC_0);
        end else if (w_extarab) begin
            w_offset = DIGIT_W'(i_code_point - CP_EXTARAB_0);
        end else begin
            w_offset = '0;
        end
    end

    assign o_class.is_plus  = (i_code_point == CP_PLUS);
    assign o_class.is_digit = w_ascii || w_arabic || w_extarab;
    assign o_class.digit    = w_offset;

endmodule : mncp_digit_decode

`default_nettype wire

>>> rtl/mncp_parse_core.sv
// ----------------------------------------------------------------------------
// mncp_parse_core
// Parser state (phase, digit count, accumulator, decided flag) and the
// single-step update for one classified codepoint.
// ----------------------------------------------------------------------------
`default_nettype none

module mncp_parse_core
    import mncp_pkg::*;
#(
    parameter int unsigned TAIL_DIGITS = 9
)
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire t_cp_class        i_class,
    input  wire logic             i_end,
    output logic                  o_produced,
    output logic [NUM_W-1:0]      o_value,
    output logic                  o_valid
);

    localparam logic [CNT_W-1:0] TAIL_LAST = CNT_W'(TAIL_DIGITS);

    t_phase             r_phase,   n_phase;
    logic [CNT_W-1:0]   r_count,   n_count;
    logic [NUM_W-1:0]   r_acc,     n_acc;
    logic               r_decided, n_decided;

    logic               w_fail;
    logic               w_done;
    logic [CNT_W-1:0]   w_count_inc;
    logic [NUM_W-1:0]   w_acc_next;

    // acc * 10 + digit, wrapping at the accumulator width
    assign w_acc_next  = (r_acc << 3) + (r_acc << 1) + NUM_W'(i_class.digit);
    assign w_count_inc = r_count + CNT_W'(1);

    // Next-state logic
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_acc     = r_acc;
        n_decided = r_decided;
        w_fail    = 1'b0;
        w_done    = 1'b0;

        if (i_step && !r_decided) begin
            unique case (r_phase)
                PH_START: begin
                    if (i_class.is_plus) begin
                        n_phase = PH_PLUS;
                    end else if (i_class.is_digit && i_class.digit == DIGIT_ZERO) begin
                        n_phase = PH_MOBILE;
                    end else begin
                        w_fail = 1'b1;
                    end
                end
                PH_PLUS: begin
                    if (i_class.is_digit && i_class.digit == DIGIT_NINE) begin
                        n_phase = PH_PLUS9;
                    end else begin
                        w_fail = 1'b1;
                    end
                end
                PH_PLUS9: begin
                    if (i_class.is_digit && i_class.digit == DIGIT_EIGHT) begin
                        n_phase = PH_MOBILE;
                    end else begin
                        w_fail = 1'b1;
                    end
                end
                PH_MOBILE: begin
                    if (i_class.is_digit && i_class.digit == DIGIT_NINE) begin
                        n_phase = PH_TAIL;
                    end else begin
                        w_fail = 1'b1;
                    end
                end
                PH_TAIL: begin
                    if (i_class.is_digit) begin
                        n_acc   = w_acc_next;
                        n_count = w_count_inc;
                        w_done  = (w_count_inc >= TAIL_LAST);
                    end else begin
                        w_fail = 1'b1;
                    end
                end
                default: begin
                    w_fail = 1'b1;
                end
            endcase
            n_decided = w_done || w_fail || i_end;
        end

        // End of string: back to the reset values
        if (i_step && i_end) begin
            n_phase   = PH_START;
            n_count   = '0;
            n_acc     = ACC_START;
            n_decided = 1'b0;
        end
    end

    // Result logic
    always_comb begin
        o_produced = i_step && !r_decided && (w_done || w_fail || i_end);
        o_valid    = w_done;
        o_value    = w_done ? w_acc_next : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START;
            r_count   <= '0;
            r_acc     <= ACC_START;
            r_decided <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_acc     <= n_acc;
            r_decided <= n_decided;
        end
    end

endmodule : mncp_parse_core

`default_nettype wire

>>> rtl/mobile_number_codepoint_parser.sv
// ----------------------------------------------------------------------------
// mobile_number_codepoint_parser
// Checks a stream of codepoints against the mobile-number format
// ("+98" or "0", then "9", then TAIL_DIGITS digits) and gives one result
// per string: the number, or zero on mismatch or early end.
// ----------------------------------------------------------------------------
// Path: input register, parser step, result register, then m_axis.
// Throughput: one codepoint per cycle while m_axis is not stalled; the
//   parser step (digit decode, phase compare and the x10 add on the
//   34-bit accumulator) sits between the input and the result register.
// Reset: synchronous, active low; clears the parser state to the start of
//   a string and empties both the input and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mobile_number_codepoint_parser
    import mncp_pkg::*;
#(
    parameter int unsigned TAIL_DIGITS = 9
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // Codepoint stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [20:0] code_point, [23:21] zero
    input  wire logic        s_axis_tlast,   // string_end

    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [33:0] number_value, [39:34] zero
    output logic [0:0]       m_axis_tuser    // [0] is_valid
);

    // Input register
    logic              r_in_valid;
    logic [CP_W-1:0]   r_in_cp;
    logic              r_in_end;

    // Result register
    logic              r_out_valid;
    logic [NUM_W-1:0]  r_out_value;
    logic              r_out_ok;

    logic              w_advance;    // pipeline moves this cycle
    logic              w_s_fire;
    logic              w_step;
    t_cp_class         w_class;
    logic              w_produced;
    logic [NUM_W-1:0]  w_value;
    logic              w_valid;

    // Advance whenever the result register is empty or being drained; the
    // input register then always hands its transaction on, so a new
    // codepoint can be taken every cycle.
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_s_fire      = s_axis_tvalid && s_axis_tready;
    assign w_step        = r_in_valid && w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Payload needs no reset; capture on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_in_cp  <= s_axis_tdata[CP_W-1:0];
            r_in_end <= s_axis_tlast;
        end
    end

    mncp_digit_decode u_decode (
        .i_code_point (r_in_cp),
        .o_class      (w_class)
    );

    mncp_parse_core #(
        .TAIL_DIGITS (TAIL_DIGITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_class    (w_class),
        .i_end      (r_in_end),
        .o_produced (w_produced),
        .o_value    (w_value),
        .o_valid    (w_valid)
    );

    // Result register: load a result only when the step produced one;
    // trailing codepoints after a decision simply drop out here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_step && w_produced;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_step && w_produced) begin
            r_out_value <= w_value;
            r_out_ok    <= w_valid;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {6'd0, r_out_value};
    assign m_axis_tuser[0] = r_out_ok;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // An accepted codepoint is held in the input register on the next cycle
    a_in_capture : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_fire |=> r_in_valid)
        else $error("accepted codepoint not captured");

    // A new result can only come from a codepoint in the input register
    a_out_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_in_valid))
        else $error("result appeared without a codepoint");

    // A rejected string always reports a zero number
    a_reject_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 40'd0))
        else $error("rejected string carries a non-zero number");

endmodule : mobile_number_codepoint_parser

`default_nettype wire
